FILE: src/rate_pid_controller_defines.svh
// assertion helpers for the rate pid controller
`ifndef RATE_PID_CONTROLLER_DEFINES_SVH
`define RATE_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication under reset
`define RPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rate_pid_controller check failed");

// next-cycle implication under reset
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rate_pid_controller check failed");

`endif

FILE: src/rpc_pkg.sv
package rpc_pkg;

	localparam int MUL_A_W   = 50;
	localparam int MUL_B_W   = 33;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_STEPS = MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	localparam int DIV_N_W   = MUL_P_W;
	localparam int DIV_D_W   = 33;
	localparam int DIV_STEPS = DIV_N_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE  = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_IMUL,
		ST_IMUL_W,
		ST_ICMP,
		ST_IDIV,
		ST_IDIV_W,
		ST_IPMUL,
		ST_IPMUL_W,
		ST_PMUL,
		ST_PMUL_W,
		ST_DMUL,
		ST_DMUL_W,
		ST_ACC,
		ST_SMUL,
		ST_SMUL_W,
		ST_SDIV,
		ST_SDIV_W,
		ST_OUT
	} rpc_state_t;

endpackage

FILE: src/rpc_mul.sv
module rpc_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpc_pkg::MUL_A_W-1:0]  a,
	input  logic [rpc_pkg::MUL_B_W-1:0]  b,
	output logic                         done,
	output logic [rpc_pkg::MUL_P_W-1:0]  prod
);
	import rpc_pkg::*;

	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_A_W-1:0]   mcand_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MUL_A_W:0]     sum;

	// shift-add, one multiplier bit a cycle, low bit first
	assign sum = {1'b0, acc_q[MUL_P_W-1:MUL_B_W]} +
		(acc_q[0] ? {1'b0, mcand_q} : {(MUL_A_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{MUL_A_W{1'b0}}, b};
			mcand_q <= a;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: src/rpc_div.sv
module rpc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpc_pkg::DIV_N_W-1:0]  dividend,
	input  logic [rpc_pkg::DIV_D_W-1:0]  divisor,
	output logic                         done,
	output logic [rpc_pkg::DIV_N_W-1:0]  quo
);
	import rpc_pkg::*;

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     trial;
	logic [DIV_D_W:0]     diff;
	logic                 ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: src/rate_pid_controller.sv
// the path from accepted item to drive valid is shortest with zero integral gain and zero span,
// longer with a nonzero span, and longest with integral clamp and scaling division
// the next item is accepted in the cycle after drive is loaded; a run-low item is taken in idle
// and gives no drive; a full output register holds the sequencer in output
// one shared shift-add multiplier and one restoring divider
// reset: arst_n clears gains, state and handshake; limits return to their defaults
`include "rate_pid_controller_defines.svh"

module rate_pid_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // target[31:0], measured[63:32]
	input  logic                          s_tuser,   // run
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // drive[31:0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import rpc_pkg::*;

	logic [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic [31:0] in_min_q, in_max_q, out_min_q, out_max_q;
	logic        wrap_q;

	rpc_state_t state_q, state_d;

	logic [32:0] err_q;
	logic [32:0] last_q;
	logic [47:0] es_q;
	logic [47:0] acc_q;
	logic [63:0] total_q;
	logic [41:0] q_q;
	logic        neg_q;
	logic        sel_hi_q;
	logic [31:0] m_tdata_q;
	logic        m_tvalid_q;

	logic               mul_start, mul_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_prod;
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [DIV_N_W-1:0] div_quo;

	logic        accept;
	logic        out_free;
	logic [32:0] span;
	logic [32:0] spmag;

	// error forming
	logic [32:0] diff, dmag;
	logic [34:0] diff35, span35, twice, folded, err35;
	logic        fold, err_fits;
	logic [32:0] err_new;

	// integral
	logic [48:0] t, tmag, t_sat_src;
	logic [47:0] t_sat;
	logic [73:0] pm74, tp, lim_hi74, lim_lo74;
	logic        lt_hi, gt_lo;
	logic [31:0] lim, lmag;
	logic [47:0] q48;
	logic [47:0] esmag;

	// gain products
	logic [63:0] ip64, pp64, dp64, add64;
	logic        ip_big;
	logic [33:0] de, demag;
	logic [32:0] emag;

	// accumulator and scaling
	logic [47:0] sh;
	logic [48:0] s49;
	logic [47:0] acc_new;
	logic [48:0] a49, amag;
	logic [32:0] ob, obmag;
	logic        q_big;
	logic [40:0] qm41;
	logic [42:0] drv43, omax43, omin43;
	logic [31:0] drive;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign span  = {in_max_q[31], in_max_q} - {in_min_q[31], in_min_q};
	assign spmag = span[32] ? (~span + 33'd1) : span;

	// error with optional fold around the input span, then 33-bit saturation
	assign diff     = {s_tdata[31], s_tdata[31:0]} - {s_tdata[63], s_tdata[63:32]};
	assign dmag     = diff[32] ? (~diff + 33'd1) : diff;
	assign twice    = {1'b0, dmag, 1'b0};
	assign span35   = {{2{span[32]}}, span};
	assign diff35   = {{2{diff[32]}}, diff};
	assign fold     = wrap_q && ($signed(twice) > $signed(span35));
	assign folded   = ($signed(diff) > 0) ? (diff35 - span35) : (diff35 + span35);
	assign err35    = fold ? folded : diff35;
	assign err_fits = (err35[34:32] == 3'b000) || (err35[34:32] == 3'b111);
	assign err_new  = err_fits ? err35[32:0] :
		(err35[34] ? {1'b1, 32'd0} : {1'b0, {32{1'b1}}});

	assign t         = {es_q[47], es_q} + {{16{err_q[32]}}, err_q};
	assign tmag      = t[48] ? (~t + 49'd1) : t;
	assign t_sat_src = t;
	assign t_sat     = (t_sat_src[48] == t_sat_src[47]) ? t_sat_src[47:0] :
		(t_sat_src[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

	// exact test of sum * gain_i against the limits scaled by 2^16
	assign pm74     = {2'b00, mul_prod[71:0]};
	assign tp       = neg_q ? (~pm74 + 74'd1) : pm74;
	assign lim_hi74 = {{26{out_max_q[31]}}, out_max_q, 16'd0};
	assign lim_lo74 = {{26{out_min_q[31]}}, out_min_q, 16'd0};
	assign lt_hi    = $signed(tp) < $signed(lim_hi74);
	assign gt_lo    = $signed(tp) > $signed(lim_lo74);

	assign lim   = sel_hi_q ? out_max_q : out_min_q;
	assign lmag  = lim[31] ? (~lim + 32'd1) : lim;
	assign q48   = div_quo[47:0];
	assign esmag = es_q[47] ? (~es_q + 48'd1) : es_q;

	// integral product saturates at 2^60
	assign ip_big = (|mul_prod[MUL_P_W-1:61]) || (mul_prod[60] && (|mul_prod[59:0]));
	assign ip64   = ip_big ? {4'b0001, 60'd0} : {3'b000, mul_prod[60:0]};
	assign pp64   = {7'd0, mul_prod[56:0]};
	assign dp64   = {6'd0, mul_prod[57:0]};

	always_comb begin
		case (state_q)
			ST_IPMUL_W: add64 = ip64;
			ST_PMUL_W:  add64 = pp64;
			default:    add64 = dp64;
		endcase
	end

	assign de    = {err_q[32], err_q} - {last_q[32], last_q};
	assign demag = de[33] ? (~de + 34'd1) : de;
	assign emag  = err_q[32] ? (~err_q + 33'd1) : err_q;

	assign sh      = total_q[63:16];
	assign s49     = {acc_q[47], acc_q} + {sh[47], sh};
	assign acc_new = (s49[48] == s49[47]) ? s49[47:0] :
		(s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

	assign a49   = {acc_q[47], acc_q} - {{17{in_min_q[31]}}, in_min_q};
	assign amag  = a49[48] ? (~a49 + 49'd1) : a49;
	assign ob    = {out_max_q[31], out_max_q} - {out_min_q[31], out_min_q};
	assign obmag = ob[32] ? (~ob + 33'd1) : ob;

	// scaled quotient saturates at 2^40
	assign q_big = (|div_quo[DIV_N_W-1:41]) || (div_quo[40] && (|div_quo[39:0]));
	assign qm41  = q_big ? {1'b1, 40'd0} : div_quo[40:0];

	assign omax43 = {{11{out_max_q[31]}}, out_max_q};
	assign omin43 = {{11{out_min_q[31]}}, out_min_q};
	assign drv43  = {q_q[41], q_q} + omin43;
	always_comb begin
		if ($signed(drv43) > $signed(omax43)) begin
			drive = out_max_q;
		end else if ($signed(drv43) < $signed(omin43)) begin
			drive = out_min_q;
		end else begin
			drive = drv43[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser) begin
					state_d = (gain_i_q != '0) ? ST_IMUL : ST_PMUL;
				end
			end
			ST_IMUL:    state_d = ST_IMUL_W;
			ST_IMUL_W:  if (mul_done) state_d = ST_ICMP;
			ST_ICMP: begin
				if (lt_hi && gt_lo) begin
					state_d = ST_IPMUL;
				end else begin
					state_d = ST_IDIV;
				end
			end
			ST_IDIV:    state_d = ST_IDIV_W;
			ST_IDIV_W:  if (div_done) state_d = ST_IPMUL;
			ST_IPMUL:   state_d = ST_IPMUL_W;
			ST_IPMUL_W: if (mul_done) state_d = ST_PMUL;
			ST_PMUL:    state_d = ST_PMUL_W;
			ST_PMUL_W:  if (mul_done) state_d = ST_DMUL;
			ST_DMUL:    state_d = ST_DMUL_W;
			ST_DMUL_W:  if (mul_done) state_d = ST_ACC;
			ST_ACC:     state_d = ST_SMUL;
			ST_SMUL:    state_d = ST_SMUL_W;
			ST_SMUL_W:  if (mul_done) state_d = ST_SDIV;
			ST_SDIV:    state_d = (span == '0) ? ST_OUT : ST_SDIV_W;
			ST_SDIV_W:  if (div_done) state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit control and operand selection
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			ST_IMUL: begin
				mul_start = 1'b1;
				mul_a     = {1'b0, tmag};
				mul_b     = {9'd0, gain_i_q};
			end
			ST_IDIV: begin
				div_start = 1'b1;
				div_n     = {35'd0, lmag, 16'd0};
				div_d     = {9'd0, gain_i_q};
			end
			ST_IPMUL: begin
				mul_start = 1'b1;
				mul_a     = {2'b00, esmag};
				mul_b     = {9'd0, gain_i_q};
			end
			ST_PMUL: begin
				mul_start = 1'b1;
				mul_a     = {17'd0, emag};
				mul_b     = {9'd0, gain_p_q};
			end
			ST_DMUL: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, demag};
				mul_b     = {9'd0, gain_d_q};
			end
			ST_SMUL: begin
				mul_start = 1'b1;
				mul_a     = {1'b0, amag};
				mul_b     = obmag;
			end
			ST_SDIV: begin
				div_start = (span != '0);
				div_n     = mul_prod;
				div_d     = spmag;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			in_min_q   <= 32'd0;
			in_max_q   <= 32'd65536;
			out_min_q  <= 32'hFFFF_0000;
			out_max_q  <= 32'd65536;
			wrap_q     <= 1'b0;
			last_q     <= '0;
			es_q       <= '0;
			acc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_GAIN_P:     gain_p_q  <= cfg_data[23:0];
					REG_GAIN_I:     gain_i_q  <= cfg_data[23:0];
					REG_GAIN_D:     gain_d_q  <= cfg_data[23:0];
					REG_INPUT_MIN:  in_min_q  <= cfg_data;
					REG_INPUT_MAX:  in_max_q  <= cfg_data;
					REG_OUTPUT_MIN: out_min_q <= cfg_data;
					REG_OUTPUT_MAX: out_max_q <= cfg_data;
					REG_WRAP_MODE:  wrap_q    <= cfg_data[0];
					default:        wrap_q    <= wrap_q;
				endcase
			end
			if (state_q == ST_ICMP && lt_hi && gt_lo) begin
				es_q <= t_sat;
			end
			if (state_q == ST_IDIV_W && div_done) begin
				es_q <= neg_q ? (~q48 + 48'd1) : q48;
			end
			if (state_q == ST_ACC) begin
				acc_q  <= acc_new;
				last_q <= err_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q   <= err_new;
				total_q <= '0;
			end
			ST_IMUL:  neg_q <= t[48];
			ST_ICMP:  sel_hi_q <= !lt_hi;
			ST_IDIV:  neg_q <= lim[31];
			ST_IPMUL: neg_q <= es_q[47];
			ST_PMUL:  neg_q <= err_q[32];
			ST_DMUL:  neg_q <= de[33];
			ST_SMUL:  neg_q <= a49[48] ^ ob[32] ^ span[32];
			ST_IPMUL_W, ST_PMUL_W, ST_DMUL_W: begin
				if (mul_done) begin
					total_q <= neg_q ? (total_q - add64) : (total_q + add64);
				end
			end
			ST_SDIV: begin
				if (span == '0) begin
					q_q <= '0;
				end
			end
			ST_SDIV_W: begin
				if (div_done) begin
					q_q <= neg_q ? (~{1'b0, qm41} + 42'd1) : {1'b0, qm41};
				end
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= drive;
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	rpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	rpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quo      (div_quo)
	);

	`RPC_ASSERT_NOW(a_mul_done_waited, mul_done, state_q == ST_IMUL_W || state_q == ST_IPMUL_W || state_q == ST_PMUL_W || state_q == ST_DMUL_W || state_q == ST_SMUL_W)
	`RPC_ASSERT_NOW(a_div_done_waited, div_done, state_q == ST_IDIV_W || state_q == ST_SDIV_W)
	`RPC_ASSERT_NEXT(a_out_loaded, state_q == ST_OUT && out_free, m_tvalid && state_q == ST_IDLE)
	`RPC_ASSERT_NOW(a_no_unit_overlap, mul_start, !div_start)

endmodule
